// File: rtl/p2c_pkg.sv
// Shared types and constants for the planar to chunky palette block.
// No dependencies; imported by every module of the block.
package p2c_pkg;

    localparam int PLANE_COUNT = 6;
    localparam int PLANE_MAX   = 6;
    localparam int PAL_DEPTH   = 64;
    localparam int PAL_AW      = $clog2(PAL_DEPTH);
    localparam int HALF_SIZE   = 32;
    localparam int HALF_AW     = $clog2(HALF_SIZE);
    localparam int COLOR_W     = 32;
    localparam int PIX_PER_GRP = 8;
    localparam int PIX_CW      = $clog2(PIX_PER_GRP);

    localparam logic [COLOR_W-1:0] OPAQUE = 32'hff000000;
    localparam logic [HALF_AW-1:0] LAST_BASE = HALF_AW'(HALF_SIZE - 1);

    localparam logic [1:0] REQ_LOAD_BASE = 2'd0;
    localparam logic [1:0] REQ_RAW_WRITE = 2'd1;
    localparam logic [1:0] REQ_CLEAR     = 2'd2;
    localparam logic [1:0] REQ_PIXELS    = 2'd3;

    typedef logic [PLANE_MAX-1:0][7:0] p2c_planes_t;

    typedef struct packed {
        logic                wr_en;
        logic [PAL_AW-1:0]   wr_addr;
        logic [COLOR_W-1:0]  wr_data;
        logic                rd_en;
        logic [PAL_AW-1:0]   rd_addr;
    } p2c_mem_req_t;

    function automatic logic [COLOR_W-1:0] half_bright(input logic [COLOR_W-1:0] c);
        half_bright = {8'hff, 1'b0, c[23:17], 1'b0, c[15:9], 1'b0, c[7:1]};
    endfunction

endpackage

// File: rtl/p2c_palette_ram.sv
// 64 x 32 palette memory with one write and one registered read port.
// Per-entry valid bits cleared at reset make unwritten entries read as zero.
// Depends on p2c_pkg.
module p2c_palette_ram
    import p2c_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  p2c_mem_req_t        req,
    output logic [COLOR_W-1:0]  rd_data
);

    logic [COLOR_W-1:0]   mem [PAL_DEPTH];
    logic [PAL_DEPTH-1:0] vld_reg;
    logic [COLOR_W-1:0]   rd_data_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_vld_reg <= vld_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

// File: rtl/p2c_seq.sv
// Request sequencer: palette writes, clear sweep and pixel read-out.
// Drives the palette memory port and the output handshake. Depends on p2c_pkg.
module p2c_seq
    import p2c_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          req_type,
    input  logic [PAL_AW-1:0]   palette_index,
    input  logic [COLOR_W-1:0]  color_value,
    input  p2c_planes_t         plane_bytes,
    input  logic [PLANE_MAX-1:0] plane_enable_mask,
    output p2c_mem_req_t        mem_req,
    output logic                out_valid,
    output logic                out_last,
    input  logic                out_ready
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_W_BASE = 3'd1;
    localparam logic [2:0] ST_W_MIR  = 3'd2;
    localparam logic [2:0] ST_W_RAW  = 3'd3;
    localparam logic [2:0] ST_C_BASE = 3'd4;
    localparam logic [2:0] ST_C_MIR  = 3'd5;
    localparam logic [2:0] ST_PIX    = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [PAL_AW-1:0]   idx_reg, idx_next;
    logic [COLOR_W-1:0]  color_reg, color_next;
    p2c_planes_t         plane_reg, plane_next;
    logic [PIX_CW-1:0]   cnt_reg, cnt_next;
    logic                vld_reg, vld_next;
    logic                last_reg, last_next;

    logic                accept;
    logic                out_free;
    logic [PLANE_MAX-1:0] plane_en;
    logic [PAL_AW-1:0]   sel;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_last  = last_reg;

    always_comb
    begin
        for (int p = 0; p < PLANE_MAX; p++)
        begin
            plane_en[p] = plane_enable_mask[p] && (p < PLANE_COUNT);
            sel[p]      = plane_reg[p][7];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        color_next = color_reg;
        plane_next = plane_reg;
        cnt_next   = cnt_reg;
        vld_next   = vld_reg && !out_ready;
        last_next  = last_reg;
        mem_req    = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next   = palette_index;
                    color_next = color_value;
                    cnt_next   = '0;
                    for (int p = 0; p < PLANE_MAX; p++)
                    begin
                        plane_next[p] = plane_en[p] ? plane_bytes[p] : 8'h00;
                    end
                    unique case (req_type)
                        REQ_LOAD_BASE: state_next = ST_W_BASE;
                        REQ_RAW_WRITE: state_next = ST_W_RAW;
                        REQ_CLEAR:     state_next = palette_index[PAL_AW-1] ? ST_IDLE
                                                                            : ST_C_BASE;
                        REQ_PIXELS:    state_next = ST_PIX;
                        default:       state_next = ST_IDLE;
                    endcase
                end
            end
            ST_W_BASE:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = {1'b0, idx_reg[HALF_AW-1:0]};
                mem_req.wr_data = color_reg;
                state_next      = ST_W_MIR;
            end
            ST_W_MIR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = {1'b1, idx_reg[HALF_AW-1:0]};
                mem_req.wr_data = half_bright(color_reg);
                state_next      = ST_IDLE;
            end
            ST_W_RAW:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = idx_reg;
                mem_req.wr_data = color_reg;
                state_next      = ST_IDLE;
            end
            ST_C_BASE:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = {1'b0, idx_reg[HALF_AW-1:0]};
                mem_req.wr_data = OPAQUE;
                state_next      = ST_C_MIR;
            end
            ST_C_MIR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = {1'b1, idx_reg[HALF_AW-1:0]};
                mem_req.wr_data = half_bright(OPAQUE);
                if (idx_reg[HALF_AW-1:0] == LAST_BASE)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + PAL_AW'(1);
                    state_next = ST_C_BASE;
                end
            end
            ST_PIX:
            begin
                if (out_free)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = sel;
                    vld_next        = 1'b1;
                    last_next       = (cnt_reg == PIX_CW'(PIX_PER_GRP - 1));
                    cnt_next        = cnt_reg + PIX_CW'(1);
                    for (int p = 0; p < PLANE_MAX; p++)
                    begin
                        plane_next[p] = {plane_reg[p][6:0], 1'b0};
                    end
                    if (cnt_reg == PIX_CW'(PIX_PER_GRP - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            vld_reg   <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            vld_reg   <= vld_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        color_reg <= color_next;
        plane_reg <= plane_next;
    end

endmodule

// File: rtl/planar_to_chunky_palette_ehb_core.sv
// Bitplane to chunky converter with a 64-entry extra-half-brite palette.
// Pixel word: eight colours, one palette read a cycle while the output is not stalled;
// the next word is taken only after its last read. Load base writes n%32 and n%32+32,
// raw write n; clear from n<32 writes n..31 and n+32..63, from n>31 none (one write port).
// rst_n (asynchronous, active low) empties the palette to zero and sets the mask to 63.
// Depends on p2c_pkg, p2c_seq and p2c_palette_ram.
module planar_to_chunky_palette_ehb_core
    import p2c_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // palette_index[5:0], color_value[37:6], plane_byte_0..5
                                   // at [45:38],[53:46],[61:54],[69:62],[77:70],[85:78], 0
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // pixel_color[31:0]
    output logic        m_tlast,   // last_pixel
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] ADDR_MASK = 3'd0;

    logic [PLANE_MAX-1:0] mask_reg;
    p2c_planes_t          planes;
    p2c_mem_req_t         mem_req;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MASK) ? {26'd0, mask_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= 6'h3f;
        end
        else if (psel && penable && pwrite && pready && (paddr == ADDR_MASK))
        begin
            mask_reg <= pwdata[PLANE_MAX-1:0];
        end
    end

    always_comb
    begin
        for (int p = 0; p < PLANE_MAX; p++)
        begin
            planes[p] = s_tdata[38 + 8*p +: 8];
        end
    end

    p2c_seq u_seq
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (s_tvalid),
        .in_ready          (s_tready),
        .req_type          (s_tuser),
        .palette_index     (s_tdata[5:0]),
        .color_value       (s_tdata[37:6]),
        .plane_bytes       (planes),
        .plane_enable_mask (mask_reg),
        .mem_req           (mem_req),
        .out_valid         (m_tvalid),
        .out_last          (m_tlast),
        .out_ready         (m_tready)
    );

    p2c_palette_ram u_ram
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (m_tdata)
    );

endmodule
